// ----- hw/rtl/des_ks_pkg.sv -----
package des_ks_pkg;

  localparam int KeyBits  = 64;
  localparam int HalfBits = 28;
  localparam int CdBits   = 56;
  localparam int SubBits  = 48;
  localparam int Rounds   = 16;
  localparam int SlotBits = 4;
  localparam int RotBits  = 5;

  localparam logic [SlotBits-1:0] LastSlot = SlotBits'(Rounds - 1);

  // first permuted choice, positions count from the key msb
  localparam logic [6:0] PC1_SEL [CdBits] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  // second permuted choice, positions count from the msb of c:d
  localparam logic [5:0] PC2_SEL [SubBits] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // total left rotation of each half after a given round
  localparam logic [RotBits-1:0] CUM_ROT [Rounds] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
  };

  // pc1 stage to round stage: key after pc1 and its order flag
  typedef struct packed {
    logic              valid;
    logic              dec;
    logic [CdBits-1:0] cd;
  } s1_t;

  // round stage to pc2 stage: rotated halves of one round
  typedef struct packed {
    logic                valid;
    logic [CdBits-1:0]   cd;
    logic [SlotBits-1:0] slot;
    logic                last;
  } s2_t;

  function automatic logic [CdBits-1:0] perm_choice1(input logic [KeyBits-1:0] key);
    logic [CdBits-1:0] r;
    r = '0;
    for (int i = 0; i < CdBits; i++) begin
      r[CdBits-1-i] = key[KeyBits - int'(PC1_SEL[i])];
    end
    return r;
  endfunction

  function automatic logic [SubBits-1:0] perm_choice2(input logic [CdBits-1:0] cd);
    logic [SubBits-1:0] r;
    r = '0;
    for (int i = 0; i < SubBits; i++) begin
      r[SubBits-1-i] = cd[CdBits - int'(PC2_SEL[i])];
    end
    return r;
  endfunction

  // rotate a half left by 1 .. 28 bits
  function automatic logic [HalfBits-1:0] rot_half(input logic [HalfBits-1:0] h,
                                                   input logic [RotBits-1:0]  n);
    logic [2*HalfBits-1:0] t;
    t = {h, h} << n;
    return t[2*HalfBits-1:HalfBits];
  endfunction

endpackage

// ----- hw/rtl/des_ks_if.sv -----
interface des_ks_in_if import des_ks_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KeyBits-1:0] key_word;

  modport source (output valid, output key_word, input ready);
  modport sink (input valid, input key_word, output ready);
endinterface

interface des_ks_out_if import des_ks_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SubBits-1:0]  subkey;
  logic [SlotBits-1:0] key_slot;
  logic                last;

  modport source (output valid, output subkey, output key_slot, output last, input ready);
  modport sink (input valid, input subkey, input key_slot, input last, output ready);
endinterface

interface des_ks_cfg_if;
  logic valid;
  logic ready;
  logic decrypt_order;

  modport source (output valid, output decrypt_order, input ready);
  modport sink (input valid, input decrypt_order, output ready);
endinterface

// ----- hw/rtl/des_ks_pc1.sv -----
module des_ks_pc1 import des_ks_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  des_ks_in_if.sink    in_ch,
  des_ks_cfg_if.sink   cfg_ch,
  output s1_t          s1_o,
  input  logic         s1_pop
);

  logic              valid_r;
  logic              dec_r;
  logic [CdBits-1:0] cd_r;
  logic              decrypt_order_r;
  logic              take;

  assign in_ch.ready  = !valid_r || s1_pop;
  assign cfg_ch.ready = 1'b1;
  assign take         = in_ch.valid && in_ch.ready;

  // order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_order_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      decrypt_order_r <= cfg_ch.decrypt_order;
    end
  end

  // pc1 stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (s1_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cd_r  <= perm_choice1(in_ch.key_word);
      dec_r <= decrypt_order_r;
    end
  end

  assign s1_o = '{valid: valid_r, dec: dec_r, cd: cd_r};

endmodule

// ----- hw/rtl/des_ks_round.sv -----
module des_ks_round import des_ks_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  s1_t  s1_i,
  output logic s1_pop,
  output s2_t  s2_o,
  input  logic s2_pop
);

  logic [SlotBits-1:0] slot_r;
  logic [SlotBits-1:0] round_idx;
  logic [RotBits-1:0]  rot_n;
  logic                valid_r;
  logic [CdBits-1:0]   cd_r;
  logic [SlotBits-1:0] slot_out_r;
  logic                last_r;
  logic                load;

  // one round per transfer; the pc1 stage is released by the transfer of the last round
  assign load      = s1_i.valid && (!valid_r || s2_pop);
  assign s1_pop    = load && (slot_r == LastSlot);
  assign round_idx = s1_i.dec ? ~slot_r : slot_r;
  assign rot_n     = CUM_ROT[round_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        slot_r  <= slot_r + 1'b1;
        valid_r <= 1'b1;
      end else if (s2_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  // rotated halves for the selected round
  always_ff @(posedge clk) begin
    if (load) begin
      cd_r       <= {rot_half(s1_i.cd[CdBits-1:HalfBits], rot_n),
                     rot_half(s1_i.cd[HalfBits-1:0], rot_n)};
      slot_out_r <= slot_r;
      last_r     <= (slot_r == LastSlot);
    end
  end

  assign s2_o = '{valid: valid_r, cd: cd_r, slot: slot_out_r, last: last_r};

endmodule

// ----- hw/rtl/des_ks_pc2.sv -----
module des_ks_pc2 import des_ks_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  s2_t          s2_i,
  output logic         s2_pop,
  des_ks_out_if.source out_ch
);

  logic                valid_r;
  logic [SubBits-1:0]  subkey_r;
  logic [SlotBits-1:0] slot_r;
  logic                last_r;
  logic                free;

  assign free   = !valid_r || out_ch.ready;
  assign s2_pop = s2_i.valid && free;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= s2_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_pop) begin
      subkey_r <= perm_choice2(s2_i.cd);
      slot_r   <= s2_i.slot;
      last_r   <= s2_i.last;
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.subkey   = subkey_r;
  assign out_ch.key_slot = slot_r;
  assign out_ch.last     = last_r;

endmodule

// ----- hw/rtl/des_key_schedule_unit.sv -----
// the first subkey passes the pc1, round and pc2 output registers; after it, one subkey per cycle
// while out_ch.ready holds, sixteen per key, with the pace set by the round sequencer stage
// the next key is taken while the sequencer emits the last round of the current one
// reset: synchronous active-low rst_n clears all stage valid bits and the round counter,
// and sets decrypt order to 0 (encryption order)
module des_key_schedule_unit import des_ks_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  des_ks_in_if.sink    in_ch,
  des_ks_out_if.source out_ch,
  des_ks_cfg_if.sink   cfg_ch
);

  s1_t  s1;
  s2_t  s2;
  logic s1_pop;
  logic s2_pop;

  // first stage: pc1 and order flag
  des_ks_pc1 u_pc1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .s1_o   (s1),
    .s1_pop (s1_pop)
  );

  // second stage: round sequencer and rotation
  des_ks_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_i   (s1),
    .s1_pop (s1_pop),
    .s2_o   (s2),
    .s2_pop (s2_pop)
  );

  // third stage: pc2 and output register
  des_ks_pc2 u_pc2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .s2_i   (s2),
    .s2_pop (s2_pop),
    .out_ch (out_ch)
  );

endmodule
